[design/mfpb_pkg.sv]
// Package for the pixel blend core: format codes, weights and the channel blend function.
`timescale 1ns / 1ps
`default_nettype none

package mfpb_pkg;

    localparam int unsigned PixelWidth  = 32;
    localparam int unsigned WeightWidth = 8;
    localparam int unsigned FormatWidth = 3;

    localparam logic [WeightWidth-1:0] FullWeight = 8'hFF;
    localparam logic [WeightWidth-1:0] HalfWeight = 8'd128;

    typedef enum logic [FormatWidth-1:0] {
        FMT_ONE_BIT  = 3'd0,
        FMT_GRAY8    = 3'd1,
        FMT_RGB332   = 3'd2,
        FMT_RGB565   = 3'd3,
        FMT_RGBA5551 = 3'd4,
        FMT_RGBA8888 = 3'd5
    } t_pixel_format;

    localparam logic [FormatWidth-1:0] FormatReset = FMT_RGBA8888;

    // (c1*mix + c2*(255-mix)) / 255, truncated. The sum stays below 2^16,
    // where (x + (x >> 8) + 1) >> 8 equals x / 255 exactly.
    function automatic logic [7:0] blend_chan(
        input logic [7:0]             c1,
        input logic [7:0]             c2,
        input logic [WeightWidth-1:0] mix
    );
        logic [WeightWidth-1:0] inv;
        logic [15:0]            sum;
        logic [16:0]            adj;
        inv = FullWeight - mix;
        sum = 16'(c1) * 16'(mix) + 16'(c2) * 16'(inv);
        adj = 17'(sum) + 17'(sum >> 8) + 17'd1;
        return adj[15:8];
    endfunction

endpackage

`default_nettype wire

[design/multi_format_pixel_blend_core.sv]
// Top level of the multi-format pixel blend core.
//
// Usage:
//   Input channel: i_valid / o_stall with i_first_pixel, i_second_pixel and
//   i_mix_weight. A transaction happens on a clock edge with i_valid high
//   and o_stall low. Output channel: o_valid / i_stall with o_blended_pixel;
//   a transaction happens with o_valid high and i_stall low.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data (pixel format).
//   o_cfg_ready is always high; change the format only while no pixel is
//   in flight.
// Timing:
//   Two register stages (input register, result register). o_valid rises
//   once an accepted pixel has moved from the input register into the result
//   register. Throughput is one pixel per clock while i_stall is low: the
//   blend is a single pass of up to eight 8x8 multiplies and a divide-by-255
//   correction between the two stages.
// Reset:
//   i_rst_n is synchronous, active low. It empties both stages and sets
//   the format to RGBA8888.
// Stall:
//   While i_stall holds a result, one more pixel is accepted into the input
//   register; o_stall rises only once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module multi_format_pixel_blend_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [mfpb_pkg::PixelWidth-1:0]       i_first_pixel,
    input  wire logic [mfpb_pkg::PixelWidth-1:0]       i_second_pixel,
    input  wire logic [mfpb_pkg::WeightWidth-1:0]      i_mix_weight,
    // output channel
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [mfpb_pkg::PixelWidth-1:0]            o_blended_pixel,
    // configuration
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [mfpb_pkg::FormatWidth-1:0]      i_cfg_data
);

    logic [mfpb_pkg::FormatWidth-1:0] r_format;

    logic                                  r_s1_valid;
    logic [mfpb_pkg::PixelWidth-1:0]       r_p1;
    logic [mfpb_pkg::PixelWidth-1:0]       r_p2;
    logic [mfpb_pkg::WeightWidth-1:0]      r_mix;

    logic                                  r_out_valid;
    logic [mfpb_pkg::PixelWidth-1:0]       r_blended;
    logic [mfpb_pkg::PixelWidth-1:0]       n_blended;

    logic adv_out;
    logic adv_s1;
    logic pick_first;
    logic [7:0] b0, b1, b2, b3;
    logic [7:0] m0, m1, m2;

    assign adv_out = !r_out_valid || !i_stall;
    assign adv_s1  = !r_s1_valid || adv_out;

    assign o_stall         = !adv_s1;
    assign o_valid         = r_out_valid;
    assign o_blended_pixel = r_blended;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= mfpb_pkg::FormatReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_format <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1 && i_valid) begin
            r_p1  <= i_first_pixel;
            r_p2  <= i_second_pixel;
            r_mix <= i_mix_weight;
        end
    end

    // blend
    assign pick_first = (r_mix >= mfpb_pkg::HalfWeight);

    always_comb begin
        b0 = '0;
        b1 = '0;
        b2 = '0;
        b3 = '0;
        m0 = '0;
        m1 = '0;
        m2 = '0;
        n_blended = '0;
        unique case (r_format)
            mfpb_pkg::FMT_ONE_BIT: begin
                n_blended[0] = pick_first ? r_p1[0] : r_p2[0];
            end
            mfpb_pkg::FMT_GRAY8: begin
                b0 = mfpb_pkg::blend_chan(r_p1[7:0], r_p2[7:0], r_mix);
                n_blended[7:0] = b0;
            end
            mfpb_pkg::FMT_RGB332: begin
                b0 = mfpb_pkg::blend_chan(8'(r_p1[1:0]), 8'(r_p2[1:0]), r_mix);
                b1 = mfpb_pkg::blend_chan(8'(r_p1[4:2]), 8'(r_p2[4:2]), r_mix);
                b2 = mfpb_pkg::blend_chan(8'(r_p1[7:5]), 8'(r_p2[7:5]), r_mix);
                n_blended[7:0] = {b2[2:0], b1[2:0], b0[1:0]};
            end
            mfpb_pkg::FMT_RGB565: begin
                b0 = mfpb_pkg::blend_chan(8'(r_p1[4:0]), 8'(r_p2[4:0]), r_mix);
                b1 = mfpb_pkg::blend_chan(8'(r_p1[10:5]), 8'(r_p2[10:5]), r_mix);
                b2 = mfpb_pkg::blend_chan(8'(r_p1[15:11]), 8'(r_p2[15:11]), r_mix);
                n_blended[15:0] = {b2[4:0], b1[5:0], b0[4:0]};
            end
            mfpb_pkg::FMT_RGBA5551: begin
                b0 = mfpb_pkg::blend_chan(8'(r_p1[4:0]), 8'(r_p2[4:0]), r_mix);
                b1 = mfpb_pkg::blend_chan(8'(r_p1[9:5]), 8'(r_p2[9:5]), r_mix);
                b2 = mfpb_pkg::blend_chan(8'(r_p1[14:10]), 8'(r_p2[14:10]), r_mix);
                n_blended[15:0] = {(pick_first ? r_p1[15] : r_p2[15]),
                                   b2[4:0], b1[4:0], b0[4:0]};
            end
            mfpb_pkg::FMT_RGBA8888: begin
                b0 = mfpb_pkg::blend_chan(r_p1[7:0], r_p2[7:0], r_mix);
                b1 = mfpb_pkg::blend_chan(r_p1[15:8], r_p2[15:8], r_mix);
                b2 = mfpb_pkg::blend_chan(r_p1[23:16], r_p2[23:16], r_mix);
                b3 = mfpb_pkg::blend_chan(r_p1[31:24], r_p2[31:24], r_mix);
                n_blended = {b3, b2, b1, b0};
            end
            default: begin
                // unused format codes give zero
                m0 = b0 | b3;
                m1 = b1;
                m2 = b2;
                n_blended = 32'(m0 & m1 & m2);
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_blended <= n_blended;
        end
    end

    // checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled with a free stage");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted transaction lost at input register");

    a_s1_moves_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv_out) |=> r_out_valid)
        else $error("stage one item lost on its way to the result register");

    a_unused_format_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_format > mfpb_pkg::FMT_RGBA8888) |-> (n_blended == '0))
        else $error("unused format gave a nonzero result");

    a_16bit_zero_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_format == mfpb_pkg::FMT_RGB565 || r_format == mfpb_pkg::FMT_RGBA5551)
            |-> (n_blended[31:16] == '0))
        else $error("16-bit format result not zero-extended");

endmodule

`default_nettype wire

[tb/sv/multi_format_pixel_blend_core_tb.sv]
// Self-checking testbench for the multi-format pixel blend core.
`timescale 1ns / 1ps

module multi_format_pixel_blend_core_tb;
    import mfpb_pkg::*;

    localparam int unsigned CycleLimit      = 200000;
    localparam int unsigned PixelsPerPhase  = 60;
    localparam int unsigned SettleCycles    = 4;
    localparam int unsigned NumFormatCodes  = 8;

    typedef struct {
        logic [PixelWidth-1:0]  first;
        logic [PixelWidth-1:0]  second;
        logic [WeightWidth-1:0] mix;
    } pix_txn_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [PixelWidth-1:0]  i_first_pixel = '0;
    logic [PixelWidth-1:0]  i_second_pixel = '0;
    logic [WeightWidth-1:0] i_mix_weight = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [PixelWidth-1:0]  o_blended_pixel;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [FormatWidth-1:0] i_cfg_data = '0;

    pix_txn_t              pix_pending[$];
    logic [PixelWidth-1:0] expected_blends[$];
    pix_txn_t              next_txn;
    logic [PixelWidth-1:0] want_pixel;
    logic [FormatWidth-1:0] fmt_model = FormatReset;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    multi_format_pixel_blend_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_pixel   (i_first_pixel),
        .i_second_pixel  (i_second_pixel),
        .i_mix_weight    (i_mix_weight),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_blended_pixel (o_blended_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // (c1*mix + c2*(255-mix)) / 255, truncated
    function automatic int unsigned weigh_channel(
        input int unsigned            c1,
        input int unsigned            c2,
        input logic [WeightWidth-1:0] mix
    );
        return (c1 * int'(mix) + c2 * (255 - int'(mix))) / 255;
    endfunction

    function automatic logic [PixelWidth-1:0] predict_blend(
        input logic [FormatWidth-1:0] fmt,
        input logic [PixelWidth-1:0]  p1,
        input logic [PixelWidth-1:0]  p2,
        input logic [WeightWidth-1:0] mix
    );
        logic [PixelWidth-1:0] blend;
        logic [PixelWidth-1:0] dominant;
        blend    = '0;
        dominant = (mix >= HalfWeight) ? p1 : p2;
        case (fmt)
            FMT_ONE_BIT: begin
                blend[0] = dominant[0];
            end
            FMT_GRAY8: begin
                blend[7:0] = 8'(weigh_channel(p1[7:0], p2[7:0], mix));
            end
            FMT_RGB332: begin
                blend[1:0] = 2'(weigh_channel(p1[1:0], p2[1:0], mix));
                blend[4:2] = 3'(weigh_channel(p1[4:2], p2[4:2], mix));
                blend[7:5] = 3'(weigh_channel(p1[7:5], p2[7:5], mix));
            end
            FMT_RGB565: begin
                blend[4:0]   = 5'(weigh_channel(p1[4:0], p2[4:0], mix));
                blend[10:5]  = 6'(weigh_channel(p1[10:5], p2[10:5], mix));
                blend[15:11] = 5'(weigh_channel(p1[15:11], p2[15:11], mix));
            end
            FMT_RGBA5551: begin
                blend[4:0]   = 5'(weigh_channel(p1[4:0], p2[4:0], mix));
                blend[9:5]   = 5'(weigh_channel(p1[9:5], p2[9:5], mix));
                blend[14:10] = 5'(weigh_channel(p1[14:10], p2[14:10], mix));
                blend[15]    = dominant[15];
            end
            FMT_RGBA8888: begin
                for (int b = 0; b < 4; b++) begin
                    blend[8*b +: 8] = 8'(weigh_channel(p1[8*b +: 8], p2[8*b +: 8], mix));
                end
            end
            default: begin
                blend = '0;
            end
        endcase
        return blend;
    endfunction

    // Format changes only with the pipe empty, so the model copy stays in step.
    task automatic program_format(input logic [FormatWidth-1:0] fmt);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fmt;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        fmt_model = fmt;
    endtask

    task automatic wait_drained;
        while (pix_pending.size() != 0 || n_accepted != n_queued ||
               expected_blends.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Driver: a new pixel goes out only when the slot is free
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            expected_blends.push_back(predict_blend(fmt_model, i_first_pixel,
                                                    i_second_pixel, i_mix_weight));
            n_accepted++;
        end
        if (!i_valid || !o_stall) begin
            if (i_rst_n && pix_pending.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                next_txn = pix_pending.pop_front();
                i_valid        <= 1'b1;
                i_first_pixel  <= next_txn.first;
                i_second_pixel <= next_txn.second;
                i_mix_weight   <= next_txn.mix;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver backpressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_blends.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, got %08h",
                         $time, o_blended_pixel);
                n_errors++;
            end else begin
                want_pixel = expected_blends.pop_front();
                if (o_blended_pixel !== want_pixel) begin
                    $display("%0t: blended pixel mismatch, expected %08h, got %08h",
                             $time, want_pixel, o_blended_pixel);
                    n_errors++;
                end
                n_checked++;
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_blends.size() + n_queued - n_accepted);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        pix_txn_t                 t;
        pix_txn_t                 directed[3];
        logic [WeightWidth-1:0]   edge_mix[6];
        int unsigned              send_by_mode[3];
        int unsigned              recv_by_mode[3];
        int unsigned              pick;

        // both boundaries of the one-bit select, plus junk above every narrow format
        directed[0] = '{32'hFFFF_FFFF, 32'h0000_0000, 8'd128};
        directed[1] = '{32'h0000_0000, 32'hFFFF_FFFF, 8'd127};
        directed[2] = '{32'hFFFF_0000, 32'h5A5A_0000, 8'd255};
        edge_mix     = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        send_by_mode = '{10, 76, 0};
        recv_by_mode = '{76, 10, 0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = send_by_mode[0];
        recv_idle_pct = recv_by_mode[0];

        // directed: reset format first, then every other code including unused ones
        for (int f = -1; f < int'(NumFormatCodes); f++) begin
            if (f == int'(FormatReset))
                continue;
            if (f >= 0)
                program_format(FormatWidth'(f));
            for (int k = 0; k < 3; k++) begin
                pix_pending.push_back(directed[k]);
                n_queued++;
            end
            wait_drained();
        end

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = send_by_mode[mode];
            recv_idle_pct = recv_by_mode[mode];
            for (int f = 0; f < int'(NumFormatCodes); f++) begin
                program_format(FormatWidth'(f));
                for (int k = 0; k < int'(PixelsPerPhase); k++) begin
                    pick = $urandom_range(9);
                    t.first  = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
                    pick = $urandom_range(9);
                    t.second = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
                    if ($urandom_range(3) == 0)
                        t.mix = edge_mix[$urandom_range(5)];
                    else
                        t.mix = WeightWidth'($urandom_range(255));
                    pix_pending.push_back(t);
                    n_queued++;
                end
                wait_drained();
            end
        end

        repeat (8) @(posedge i_clk);
        if (expected_blends.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_blends.size());
            n_errors++;
        end

        $display("Covered %0d blended pixels over all eight format codes, reset default first.",
                 n_checked);
        $display("Flow control: light sender gaps with heavy backpressure, the reverse, "
                 , "then full rate; %0d mismatches.", n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
design/mfpb_pkg.sv
design/multi_format_pixel_blend_core.sv
tb/sv/multi_format_pixel_blend_core_tb.sv
